// ----- src/dshd_pkg.sv -----
package dshd_pkg;

  // Command codes on the action field
  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_TURN = 2'd1,
    ACT_LINE = 2'd2
  } action_t;

  // Configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t REG_TURN_SCALE = 1'b0;
  localparam cfg_idx_t REG_LINE_SCALE = 1'b1;

  localparam int unsigned CFG_W  = 16;
  localparam int unsigned DEG_W  = 10;
  localparam int unsigned ADV_W  = 16;
  localparam int unsigned COIL_W = 4;
  localparam int unsigned PROD_W = 32;

  localparam logic [CFG_W-1:0] TURN_SCALE_RST = 16'd1024;
  localparam logic [CFG_W-1:0] LINE_SCALE_RST = 16'd1024;

  // floor(p / 90) == (p * RECIP_90) >> RECIP_SHIFT, exact for p < 2^28
  localparam int unsigned RECIP_W     = 26;
  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned TURN_PROD_W = 25;
  localparam logic [RECIP_W-1:0] RECIP_90 = 26'd47721859;

  // Q8.8 advance: drop the fraction bits
  localparam int unsigned FRAC_BITS = 8;
  localparam int unsigned QUOT_W    = PROD_W - FRAC_BITS;

  // Coil patterns of the eight half steps
  localparam logic [COIL_W-1:0] COIL_A  = 4'b0001;
  localparam logic [COIL_W-1:0] COIL_AB = 4'b0011;
  localparam logic [COIL_W-1:0] COIL_B  = 4'b0010;
  localparam logic [COIL_W-1:0] COIL_BC = 4'b0110;
  localparam logic [COIL_W-1:0] COIL_C  = 4'b0100;
  localparam logic [COIL_W-1:0] COIL_CD = 4'b1100;
  localparam logic [COIL_W-1:0] COIL_D  = 4'b1000;
  localparam logic [COIL_W-1:0] COIL_DA = 4'b1001;
  localparam logic [COIL_W-1:0] COIL_OFF = 4'b0000;

  function automatic logic [COIL_W-1:0] half_step(input logic [2:0] phase);
    logic [COIL_W-1:0] pat;
    unique case (phase)
      3'd0: pat = COIL_A;
      3'd1: pat = COIL_AB;
      3'd2: pat = COIL_B;
      3'd3: pat = COIL_BC;
      3'd4: pat = COIL_C;
      3'd5: pat = COIL_CD;
      3'd6: pat = COIL_D;
      3'd7: pat = COIL_DA;
      default: pat = COIL_OFF;
    endcase
    return pat;
  endfunction

endpackage

// ----- src/dshd_if.sv -----
interface dshd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic signed [dshd_pkg::DEG_W-1:0] degrees;
  logic signed [dshd_pkg::ADV_W-1:0] advance;
  logic        cancel;
  logic        executing;

  modport source(output valid, action, degrees, advance, cancel, executing, input ready);
  modport sink(input valid, action, degrees, advance, cancel, executing, output ready);
endinterface

interface dshd_out_if;
  logic        valid;
  logic        ready;
  logic [dshd_pkg::COIL_W-1:0] left_coils;
  logic [dshd_pkg::COIL_W-1:0] right_coils;
  logic        move_done;
  logic        busy_res;

  modport source(output valid, left_coils, right_coils, move_done, busy_res, input ready);
  modport sink(input valid, left_coils, right_coils, move_done, busy_res, output ready);
endinterface

// ----- src/dual_stepper_halfstep_driver_core.sv -----
// Dual half-step stepper driver. Two 4-coil motors are stepped through the
// eight-phase order 0001, 0011, 0010, 0110, 0100, 1100, 1000, 1001. A turn
// item loads both signed counts with trunc(-turn_scale*degrees/90); a straight
// item loads right with trunc(line_scale*advance/256) (advance is Q8.8) and
// left with its negation, both saturated to COUNT_BITS. A tick item with
// executing set steps each motor whose count is non-zero (latch pattern, move
// phase, count toward zero); cancel then zeroes both counts. A tick that finds
// both counts zero switches the coils off and flags move_done. Every item
// gives exactly one result. Rate: one item per clock while out_ch takes
// results. The accepting edge loads the input register; the 16x16 product
// stage, the reciprocal-multiply (divide by 90) and saturate stage, and the
// state/result register follow in that order up to out_ch. Stalls on out_ch
// back up stage by stage; empty stages keep taking items. turn_scale and
// line_scale are written through cfg_we/cfg_idx/cfg_data; the user must do
// so only while no item is in flight, which the block does not enforce.
// They reset to 1024. Counts reset to 8, phases and coils to 0.
module dual_stepper_halfstep_driver_core #(
  parameter int unsigned COUNT_BITS = 32  // signed step count width, 16..32
) (
  input  logic                      clk,
  input  logic                      rst,
  dshd_in_if.sink                   in_ch,
  dshd_out_if.source                out_ch,
  input  logic                      cfg_we,
  input  dshd_pkg::cfg_idx_t        cfg_idx,
  input  logic [dshd_pkg::CFG_W-1:0] cfg_data
);

  localparam int unsigned LIM_W = dshd_pkg::PROD_W + 1;
  // magnitude of the most negative count
  localparam logic [LIM_W-1:0] LIM = LIM_W'(1) << (COUNT_BITS - 1);
  localparam logic signed [COUNT_BITS-1:0] CMIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
  localparam logic signed [COUNT_BITS-1:0] CMAX = ~CMIN;
  localparam logic signed [COUNT_BITS-1:0] ONE  = COUNT_BITS'(1);
  localparam logic signed [COUNT_BITS-1:0] CNT_RST = COUNT_BITS'(8);

  // config registers
  logic [dshd_pkg::CFG_W-1:0] turn_scale;
  logic [dshd_pkg::CFG_W-1:0] line_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_scale <= dshd_pkg::TURN_SCALE_RST;
      line_scale <= dshd_pkg::LINE_SCALE_RST;
    end else if (cfg_we) begin
      if (cfg_idx == dshd_pkg::REG_TURN_SCALE) turn_scale <= cfg_data;
      if (cfg_idx == dshd_pkg::REG_LINE_SCALE) line_scale <= cfg_data;
    end
  end

  // pipeline flow control: a stage takes a new item when empty or draining
  logic v1, v2, v3, ov;
  logic out_free, free3, free2, free1, adv3;

  assign out_free = !ov || out_ch.ready;
  assign free3    = !v3 || out_free;
  assign free2    = !v2 || free3;
  assign free1    = !v1 || free2;
  assign adv3     = v3 && out_free;
  assign in_ch.ready = free1;

  // stage 1: input register
  logic [1:0] s1_action;
  logic signed [dshd_pkg::DEG_W-1:0] s1_degrees;
  logic signed [dshd_pkg::ADV_W-1:0] s1_advance;
  logic s1_cancel, s1_exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (free1) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (free1 && in_ch.valid) begin
      s1_action  <= in_ch.action;
      s1_degrees <= in_ch.degrees;
      s1_advance <= in_ch.advance;
      s1_cancel  <= in_ch.cancel;
      s1_exec    <= in_ch.executing;
    end
  end

  // stage 1 -> 2: magnitude product, sign kept aside
  logic [dshd_pkg::DEG_W-1:0]  deg_mag;
  logic [dshd_pkg::ADV_W-1:0]  adv_mag;
  logic [dshd_pkg::CFG_W-1:0]  mul_a;
  logic [dshd_pkg::ADV_W-1:0]  mul_b;
  logic [dshd_pkg::PROD_W-1:0] prod;
  logic                        is_turn1, neg1;

  always_comb begin
    is_turn1 = (s1_action == dshd_pkg::ACT_TURN);
    deg_mag  = s1_degrees[dshd_pkg::DEG_W-1] ? -s1_degrees : s1_degrees;
    adv_mag  = s1_advance[dshd_pkg::ADV_W-1] ? -s1_advance : s1_advance;
    mul_a    = is_turn1 ? turn_scale : line_scale;
    mul_b    = is_turn1 ? dshd_pkg::ADV_W'(deg_mag) : adv_mag;
    prod     = dshd_pkg::PROD_W'(mul_a) * dshd_pkg::PROD_W'(mul_b);
    // turn count runs opposite to the angle
    neg1     = is_turn1 ? !s1_degrees[dshd_pkg::DEG_W-1] : s1_advance[dshd_pkg::ADV_W-1];
  end

  logic [1:0] s2_action;
  logic [dshd_pkg::PROD_W-1:0] s2_prod;
  logic s2_neg, s2_cancel, s2_exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (free2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (free2 && v1) begin
      s2_action <= s1_action;
      s2_prod   <= prod;
      s2_neg    <= neg1;
      s2_cancel <= s1_cancel;
      s2_exec   <= s1_exec;
    end
  end

  // stage 2 -> 3: divide (reciprocal or shift), apply sign, saturate
  localparam int unsigned RP_W = dshd_pkg::RECIP_W * 2;
  logic [RP_W-1:0]                rp;
  logic [dshd_pkg::QUOT_W-1:0]    quot;
  logic [LIM_W-1:0]               q_ext;
  logic signed [COUNT_BITS-1:0]   r_val, l_val;

  always_comb begin
    rp = RP_W'(s2_prod[dshd_pkg::TURN_PROD_W-1:0]) * RP_W'(dshd_pkg::RECIP_90);
    if (s2_action == dshd_pkg::ACT_TURN) begin
      quot = dshd_pkg::QUOT_W'(rp[RP_W-1:dshd_pkg::RECIP_SHIFT]);
    end else begin
      quot = s2_prod[dshd_pkg::PROD_W-1:dshd_pkg::FRAC_BITS];
    end
    q_ext = LIM_W'(quot);
    if (s2_neg) begin
      r_val = (q_ext > LIM) ? CMIN : COUNT_BITS'(-q_ext);
    end else begin
      r_val = (q_ext >= LIM) ? CMAX : COUNT_BITS'(q_ext);
    end
    if (s2_action == dshd_pkg::ACT_TURN) begin
      l_val = r_val;
    end else begin
      l_val = (r_val == CMIN) ? CMAX : -r_val;
    end
  end

  logic [1:0] s3_action;
  logic signed [COUNT_BITS-1:0] s3_left, s3_right;
  logic s3_cancel, s3_exec;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (free3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (free3 && v2) begin
      s3_action <= s2_action;
      s3_left   <= l_val;
      s3_right  <= r_val;
      s3_cancel <= s2_cancel;
      s3_exec   <= s2_exec;
    end
  end

  // stage 3: motor state update, in item order
  logic signed [COUNT_BITS-1:0] left_count, right_count;
  logic signed [COUNT_BITS-1:0] left_count_next, right_count_next;
  logic [2:0] left_phase, right_phase, left_phase_next, right_phase_next;
  logic [dshd_pkg::COIL_W-1:0] left_drive, right_drive;
  logic [dshd_pkg::COIL_W-1:0] left_drive_next, right_drive_next;
  logic done_next;

  always_comb begin
    left_count_next  = left_count;
    right_count_next = right_count;
    left_phase_next  = left_phase;
    right_phase_next = right_phase;
    left_drive_next  = left_drive;
    right_drive_next = right_drive;
    done_next        = 1'b0;
    priority if (s3_action == dshd_pkg::ACT_TURN || s3_action == dshd_pkg::ACT_LINE) begin
      left_count_next  = s3_left;
      right_count_next = s3_right;
    end else if (s3_action == dshd_pkg::ACT_TICK && s3_exec) begin
      if (left_count == '0 && right_count == '0) begin
        left_drive_next  = dshd_pkg::COIL_OFF;
        right_drive_next = dshd_pkg::COIL_OFF;
        done_next        = 1'b1;
      end else begin
        if (left_count != '0) begin
          left_drive_next = dshd_pkg::half_step(left_phase);
          if (!left_count[COUNT_BITS-1]) begin
            left_phase_next = left_phase + 3'd1;
            left_count_next = left_count - ONE;
          end else begin
            left_phase_next = left_phase - 3'd1;
            left_count_next = left_count + ONE;
          end
        end
        if (right_count != '0) begin
          right_drive_next = dshd_pkg::half_step(right_phase);
          if (!right_count[COUNT_BITS-1]) begin
            right_phase_next = right_phase + 3'd1;
            right_count_next = right_count - ONE;
          end else begin
            right_phase_next = right_phase - 3'd1;
            right_count_next = right_count + ONE;
          end
        end
        if (s3_cancel) begin
          left_count_next  = '0;
          right_count_next = '0;
        end
      end
    end else begin
      // unknown action or disabled tick: no change
      done_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_count  <= CNT_RST;
      right_count <= CNT_RST;
      left_phase  <= 3'd0;
      right_phase <= 3'd0;
      left_drive  <= dshd_pkg::COIL_OFF;
      right_drive <= dshd_pkg::COIL_OFF;
    end else if (adv3) begin
      left_count  <= left_count_next;
      right_count <= right_count_next;
      left_phase  <= left_phase_next;
      right_phase <= right_phase_next;
      left_drive  <= left_drive_next;
      right_drive <= right_drive_next;
    end
  end

  // result register
  logic [dshd_pkg::COIL_W-1:0] o_left, o_right;
  logic o_done, o_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_free) begin
      ov <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      o_left  <= left_drive_next;
      o_right <= right_drive_next;
      o_done  <= done_next;
      o_busy  <= (left_count_next != '0) || (right_count_next != '0);
    end
  end

  assign out_ch.valid       = ov;
  assign out_ch.left_coils  = o_left;
  assign out_ch.right_coils = o_right;
  assign out_ch.move_done   = o_done;
  assign out_ch.busy_res    = o_busy;

endmodule

// ----- src/dshd_checker.sv -----
module dshd_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] left_coils,
  input logic [3:0] right_coils,
  input logic       move_done,
  input logic       busy_res
);

  // a finished move reports the coils switched off
  a_done_coils_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && move_done |-> left_coils == 4'b0000 && right_coils == 4'b0000)
    else $error("move_done with coils still driven");

  // a finished move leaves no steps pending
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && move_done |-> !busy_res)
    else $error("move_done while busy");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_coils) && $stable(right_coils)
      && $stable(move_done) && $stable(busy_res))
    else $error("stalled result changed");

endmodule

bind dual_stepper_halfstep_driver_core dshd_checker u_dshd_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .left_coils (out_ch.left_coils),
  .right_coils(out_ch.right_coils),
  .move_done  (out_ch.move_done),
  .busy_res   (out_ch.busy_res)
);

// ----- tb/dual_stepper_halfstep_driver_core_tb.sv -----
`timescale 1ns / 1ps

module dual_stepper_halfstep_driver_core_tb;

  localparam int COUNT_BITS = 32;
  // Action code that the block must ignore (no state change)
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  // Quiet cycles (nothing accepted on either side) before the run is abandoned.
  // Worst case is the long receiver hold plus a random stall run.
  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 200;  // long receiver hold-off, fills the pipe
  localparam int SETTLE_CYCLES = 8;  // margin past the pipeline latency
  localparam int MOVE_TICK_CAP = 60; // long moves get cancelled after this
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 240;

  // Half-step coil sequence, phase 0..7
  localparam logic [dshd_pkg::COIL_W-1:0] HALF_STEPS [8] = '{
    dshd_pkg::COIL_A, dshd_pkg::COIL_AB, dshd_pkg::COIL_B, dshd_pkg::COIL_BC,
    dshd_pkg::COIL_C, dshd_pkg::COIL_CD, dshd_pkg::COIL_D, dshd_pkg::COIL_DA
  };

  typedef struct packed {
    logic [1:0] action;
    logic signed [dshd_pkg::DEG_W-1:0] degrees;
    logic signed [dshd_pkg::ADV_W-1:0] advance;
    logic cancel;
    logic executing;
  } cmd_t;

  typedef struct packed {
    logic [dshd_pkg::COIL_W-1:0] left_coils;
    logic [dshd_pkg::COIL_W-1:0] right_coils;
    logic move_done;
    logic busy_res;
  } drive_t;

  // Tracks both motors, predicts the coil drive for every accepted command and
  // checks results in order. Index 0 is the left motor, 1 the right one.
  class drive_tracker;
    bit [dshd_pkg::CFG_W-1:0] turn_scale;
    bit [dshd_pkg::CFG_W-1:0] line_scale;
    longint count [2];
    bit [2:0] phase [2];
    bit [dshd_pkg::COIL_W-1:0] drive [2];
    drive_t pending_drives [$];
    int errors;
    int commands;
    int moves_finished;

    function new();
      turn_scale = dshd_pkg::TURN_SCALE_RST;
      line_scale = dshd_pkg::LINE_SCALE_RST;
      count = '{8, 8};
      phase = '{3'd0, 3'd0};
      drive = '{dshd_pkg::COIL_OFF, dshd_pkg::COIL_OFF};
    endfunction

    function longint saturate(longint v);
      longint hi;
      hi = (longint'(1) <<< (COUNT_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function bit busy();
      return count[0] != 0 || count[1] != 0;
    endfunction

    function void step_motor(int m);
      if (count[m] == 0) return;
      drive[m] = HALF_STEPS[phase[m]];
      if (count[m] > 0) begin
        phase[m] = phase[m] + 3'd1;
        count[m] = count[m] - 1;
      end else begin
        phase[m] = phase[m] - 3'd1;
        count[m] = count[m] + 1;
      end
    endfunction

    function void accept_cmd(cmd_t c);
      drive_t want;
      longint r;
      bit done;
      done = 1'b0;
      case (c.action)
        dshd_pkg::ACT_TURN: begin
          // trunc toward zero: SV signed division does that
          r = saturate((-longint'(turn_scale) * longint'(c.degrees)) / 90);
          count[0] = r;
          count[1] = r;
        end
        dshd_pkg::ACT_LINE: begin
          r = saturate((longint'(line_scale) * longint'(c.advance)) / 256);
          count[1] = r;
          count[0] = saturate(-r);
        end
        dshd_pkg::ACT_TICK: begin
          if (c.executing) begin
            if (!busy()) begin
              // idle tick: coils off, cancel is moot
              drive = '{dshd_pkg::COIL_OFF, dshd_pkg::COIL_OFF};
              done = 1'b1;
              moves_finished++;
            end else begin
              step_motor(0);
              step_motor(1);
              if (c.cancel) count = '{0, 0};
            end
          end
        end
        default: ;
      endcase
      want.left_coils = drive[0];
      want.right_coils = drive[1];
      want.move_done = done;
      want.busy_res = busy();
      pending_drives.push_back(want);
      commands++;
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected result left=%h right=%h done=%b busy=%b", $time,
                 got.left_coils, got.right_coils, got.move_done, got.busy_res);
        errors++;
        return;
      end
      want = pending_drives.pop_front();
      if (got.left_coils !== want.left_coils || got.right_coils !== want.right_coils ||
          got.move_done !== want.move_done || got.busy_res !== want.busy_res) begin
        $display("%0t: mismatch expected left=%h right=%h done=%b busy=%b", $time,
                 want.left_coils, want.right_coils, want.move_done, want.busy_res);
        $display("%0t:            actual left=%h right=%h done=%b busy=%b", $time,
                 got.left_coils, got.right_coils, got.move_done, got.busy_res);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  dshd_pkg::cfg_idx_t cfg_idx;
  logic [dshd_pkg::CFG_W-1:0] cfg_data;

  dshd_in_if in_ch();
  dshd_out_if out_ch();

  drive_tracker tracker;
  int send_idle_pct;  // chance (%) the sender waits, per try, before offering an item
  int stall_pct;      // chance (%) the receiver holds ready low
  bit hold_request;   // asks the receiver for one long hold-off

  dual_stepper_halfstep_driver_core #(.COUNT_BITS(COUNT_BITS)) dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off counted here
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result side: every accepted result is checked against the oldest prediction
  always @(posedge clk) begin : result_monitor
    drive_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.left_coils = out_ch.left_coils;
      got.right_coils = out_ch.right_coils;
      got.move_done = out_ch.move_done;
      got.busy_res = out_ch.busy_res;
      tracker.check_drive(got);
    end
  end

  // Watchdog: gives up once nothing moves on either channel for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("dual_stepper_halfstep_driver_core_tb: done, errors");
    $finish;
  end

  function automatic cmd_t make_cmd(logic [1:0] action, int deg, int adv, bit cancel,
                                    bit executing);
    cmd_t c;
    c.action = action;
    c.degrees = deg[dshd_pkg::DEG_W-1:0];
    c.advance = adv[dshd_pkg::ADV_W-1:0];
    c.cancel = cancel;
    c.executing = executing;
    return c;
  endfunction

  // Offer one item, with optional idle cycles first; returns once accepted.
  // The prediction is updated at acceptance, so tracker state is always current.
  task automatic issue_command(cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.action <= c.action;
    in_ch.degrees <= c.degrees;
    in_ch.advance <= c.advance;
    in_ch.cancel <= c.cancel;
    in_ch.executing <= c.executing;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tracker.accept_cmd(c);
  endtask

  // Stop offering and wait until every predicted result has come back
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (tracker.pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both step-scale registers, back to back; only while the block is idle
  task automatic load_step_scales(logic [dshd_pkg::CFG_W-1:0] turn,
                                  logic [dshd_pkg::CFG_W-1:0] line);
    cfg_we <= 1'b1;
    cfg_idx <= dshd_pkg::REG_TURN_SCALE;
    cfg_data <= turn;
    @(posedge clk);
    cfg_idx <= dshd_pkg::REG_LINE_SCALE;
    cfg_data <= line;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.turn_scale = turn;
    tracker.line_scale = line;
  endtask

  // Mostly well-formed moves: a load, then ticks until the done tick. Some moves
  // are cut short by a new load, some are cancelled, some ticks are disabled,
  // and about one pass in ten of the loop sends a single item of pure noise.
  task automatic run_motion_mix(int n);
    int sent;
    int deg;
    int adv;
    int ticks;
    int cut_at;
    bit was_idle;
    bit exec;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(99) < 10) begin
        issue_command(make_cmd(2'($urandom_range(3)), $urandom, $urandom,
                               1'($urandom_range(1)), 1'($urandom_range(1))));
        sent++;
      end else begin
        if ($urandom_range(1)) begin
          if ($urandom_range(3) == 0) deg = $urandom;
          else begin
            deg = $urandom_range(60);
            if ($urandom_range(1)) deg = -deg;
          end
          issue_command(make_cmd(dshd_pkg::ACT_TURN, deg, $urandom, 1'($urandom_range(1)),
                                 1'($urandom_range(1))));
        end else begin
          if ($urandom_range(3) == 0) adv = $urandom;
          else begin
            adv = $urandom_range(400);
            if ($urandom_range(1)) adv = -adv;
          end
          issue_command(make_cmd(dshd_pkg::ACT_LINE, $urandom, adv, 1'($urandom_range(1)),
                                 1'($urandom_range(1))));
        end
        sent++;
        cut_at = ($urandom_range(9) == 0) ? $urandom_range(1, 10) : MOVE_TICK_CAP;
        ticks = 0;
        while (ticks < cut_at && sent < n) begin
          was_idle = !tracker.busy();
          exec = ($urandom_range(19) != 0);
          issue_command(make_cmd(dshd_pkg::ACT_TICK, $urandom, $urandom,
                                 $urandom_range(39) == 0, exec));
          ticks++;
          sent++;
          if (was_idle && exec) break;
        end
        // a move too long to finish is cancelled
        if (ticks == MOVE_TICK_CAP && tracker.busy()) begin
          issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b1, 1'b1));
          sent++;
        end
      end
    end
  endtask

  initial begin : main
    int turn_list [PHASES];
    int line_list [PHASES];
    int send_list [4];
    int stall_list [4];
    turn_list = '{0, 65535, 45, 7, 90, 1, 65535, 360};
    line_list = '{65535, 0, 20, 3, 256, 1, 65535, 64};
    // idle modes: none, sender only, receiver only, both
    send_list = '{0, 67, 0, 28};
    stall_list = '{0, 0, 67, 28};
    tracker = new();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.action <= dshd_pkg::ACT_TICK;
    in_ch.degrees <= '0;
    in_ch.advance <= '0;
    in_ch.cancel <= 1'b0;
    in_ch.executing <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= dshd_pkg::REG_TURN_SCALE;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part, reset scales (1024 / 1024).
    // Counts come out of reset at 8, so the first ticks step right away.
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b0, 1'b1));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b0, 1'b1));
    // unknown action: no state change
    issue_command(make_cmd(ACT_UNUSED, -1, -1, 1'b1, 1'b1));
    // disabled tick, cancel set but ignored
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b1, 1'b0));
    // cancel mid-move, then cancel on an idle tick (no effect, move done)
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b1, 1'b1));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b1, 1'b1));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b0, 1'b1));
    // small turns: fractional counts truncate toward zero, phases run backward for a positive angle
    issue_command(make_cmd(dshd_pkg::ACT_TURN, 1, 0, 1'b0, 1'b0));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b0, 1'b1));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b0, 1'b1));
    issue_command(make_cmd(dshd_pkg::ACT_TURN, -1, 0, 1'b0, 1'b0));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b0, 1'b1));
    // angle field extremes and zero
    issue_command(make_cmd(dshd_pkg::ACT_TURN, -512, 0, 1'b0, 1'b0));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b1, 1'b1));
    issue_command(make_cmd(dshd_pkg::ACT_TURN, 511, 0, 1'b0, 1'b0));
    issue_command(make_cmd(dshd_pkg::ACT_TURN, 0, 0, 1'b0, 1'b0));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b0, 1'b1));
    // straight moves: advance extremes and smallest fractions
    issue_command(make_cmd(dshd_pkg::ACT_LINE, 0, 32767, 1'b0, 1'b0));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b0, 1'b1));
    issue_command(make_cmd(dshd_pkg::ACT_LINE, 0, -32768, 1'b0, 1'b0));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b1, 1'b1));
    issue_command(make_cmd(dshd_pkg::ACT_LINE, 0, 1, 1'b0, 1'b0));
    issue_command(make_cmd(dshd_pkg::ACT_LINE, 0, -1, 1'b0, 1'b0));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b0, 1'b1));
    issue_command(make_cmd(dshd_pkg::ACT_TICK, 0, 0, 1'b1, 1'b1));
    settle();

    // Random part: one scale setting and one idle mode per phase.
    // Phase 0 runs flat out and gets the long receiver hold-off.
    for (int p = 0; p < PHASES; p++) begin
      load_step_scales(dshd_pkg::CFG_W'(turn_list[p]), dshd_pkg::CFG_W'(line_list[p]));
      send_idle_pct = send_list[p % 4];
      stall_pct = stall_list[p % 4];
      if (p == 0) hold_request = 1'b1;
      run_motion_mix(ITEMS_PER_PHASE);
      settle();
    end

    $display("covered %0d commands over %0d step-scale settings and 4 idle modes",
             tracker.commands, PHASES + 1);
    $display("%0d moves ran to the done tick, %0d mismatches", tracker.moves_finished,
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("dual_stepper_halfstep_driver_core_tb: done, clean");
    end else begin
      $display("dual_stepper_halfstep_driver_core_tb: done, errors");
    end
    $finish;
  end

endmodule
